>>> sv/mcss_pkg.sv
package mcss_pkg;

  // motion / switch / relay codes (code three reads as idle)
  localparam logic [1:0] MOT_IDLE  = 2'd0;
  localparam logic [1:0] MOT_OPEN  = 2'd1;
  localparam logic [1:0] MOT_CLOSE = 2'd2;

  // remote command codes
  localparam logic [2:0] FUNC_NONE        = 3'd0;
  localparam logic [2:0] FUNC_MARK_OPEN   = 3'd1;
  localparam logic [2:0] FUNC_MARK_CLOSED = 3'd2;
  localparam logic [2:0] FUNC_ENTER_SET   = 3'd3;
  localparam logic [2:0] FUNC_EXIT_SET    = 3'd4;

  // reported mode
  localparam logic [1:0] MODE_LOCAL = 2'd0;
  localparam logic [1:0] MODE_AUTO  = 2'd1;
  localparam logic [1:0] MODE_SET   = 2'd2;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN_S   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NO_PULSE_MS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REBOOT_MS   = 3'd3;

  localparam int unsigned RUN_S_W  = 11;
  localparam int unsigned RUN_MS_W = 21;
  localparam int unsigned MS16_W   = 16;
  localparam int unsigned SEQ_W    = 32;

  localparam logic [RUN_S_W-1:0]  RUN_S_MIN       = 11'd30;
  localparam logic [RUN_S_W-1:0]  RUN_S_MAX       = 11'd1800;
  localparam logic [RUN_S_W-1:0]  RUN_S_RST       = 11'd300;
  localparam logic [RUN_MS_W-1:0] MS_PER_S        = 21'd1000;
  localparam logic [RUN_MS_W-1:0] RUN_MS_RST      = 21'd300000;
  localparam logic [MS16_W-1:0]   NO_PULSE_MS_RST = 16'd5000;
  localparam logic [7:0]          TOGGLE_THR_RST  = 8'd3;
  localparam logic [MS16_W-1:0]   REBOOT_MS_RST   = 16'd500;

  // floor(x/1000) = (x * SEC_RECIP) >> SEC_SHIFT for any 21-bit x
  localparam int unsigned SEC_SHIFT = 31;
  localparam logic [21:0] SEC_RECIP = 22'd2147484;

  typedef struct packed {
    logic [2:0]         func;
    logic [1:0]         switch_raw;
    logic [1:0]         remote_desired;
    logic               can_open;
    logic               can_close;
    logic [1:0]         relay_state;
    logic signed [31:0] pulse_position;
    logic               position_fault;
    logic [15:0]        delta_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  commanded_motion;
    logic [1:0]  mode;
    logic        panic;
    logic        reboot_request;
    logic        drive_active;
    logic [10:0] runtime_seconds;
    logic        clear_remote;
    logic        simulation_on;
    logic        mark_open;
    logic        mark_closed;
  } out_word_t;

  typedef struct packed {
    logic [RUN_MS_W-1:0] max_run_ms;
    logic [MS16_W-1:0]   no_pulse_ms;
    logic [7:0]          toggle_thr;
    logic [MS16_W-1:0]   reboot_ms;
    logic                run_restart;
  } cfg_t;

  function automatic logic [1:0] motion_of(input logic [1:0] v);
    return (v == 2'd3) ? MOT_IDLE : v;
  endfunction

endpackage

>>> sv/mcss_stream_if.sv
interface mcss_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/motor_command_safety_supervisor_top.sv
// Motor command safety supervisor.
// in_i carries one tick word per control-loop period: wall switch, remote
// desired motion and command, limit flags, relay state, pulse position,
// position fault and elapsed ms. out_o returns exactly one result word per
// tick word, in order: commanded motion, mode, panic, drive timing and the
// one-word pulses (reboot request, clear remote, mark open / closed).
// The config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes a register
// with no read-back; write only while no word is in flight.
// An accepted word enters the input register, then one pass of the
// supervisor logic writes its result into the result register.
// Throughput: one word per cycle while out_o.ready is high; the whole tick
// update fits in one pass, so the next word enters while the previous
// result waits in the output register.
// Stall: when out_o.ready is low the result register holds; one more word
// can sit in the input register, then in_i.ready drops.
// Reset (async, rst_ni low): both registers empty, supervisor state idle,
// registers back to 300 s, 5000 ms, 3 and 500 ms.
module motor_command_safety_supervisor_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mcss_stream_if.sink                     in_i,
  mcss_stream_if.source                   out_o,
  input  logic                            cfg_we_i,
  input  logic [mcss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcss_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  mcss_pkg::in_word_t  in_q;
  logic                in_vld_q;
  mcss_pkg::out_word_t out_q;
  logic                out_vld_q;
  mcss_pkg::out_word_t res;
  mcss_pkg::cfg_t      cfg;
  logic                step_en;
  logic                in_acc;

  // word advances when the result register is free or being drained
  assign step_en   = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || step_en;
  assign in_acc    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (step_en) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step_en) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  mcss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mcss_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .word_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // a processed word always lands in the result register
  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> out_vld_q)
    else $error("processed word did not reach result register");

  // a held input word is never dropped while blocked
  a_hold_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !step_en) |=> in_vld_q)
    else $error("blocked input word lost");

  // panic forces the drive off
  a_panic_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.panic) |-> (out_q.commanded_motion == mcss_pkg::MOT_IDLE))
    else $error("motion commanded during panic");

  // run seconds only while timed, and never beyond the cap
  a_secs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> ((out_q.drive_active || (out_q.runtime_seconds == '0))
                   && (out_q.runtime_seconds <= mcss_pkg::RUN_S_MAX)))
    else $error("runtime seconds out of range");

endmodule

>>> sv/mcss_cfg.sv
module mcss_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mcss_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcss_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output mcss_pkg::cfg_t                    cfg_o
);

  logic [mcss_pkg::RUN_S_W-1:0]  max_run_s_q;
  logic [mcss_pkg::RUN_MS_W-1:0] max_run_ms_q;
  logic [mcss_pkg::MS16_W-1:0]   no_pulse_ms_q;
  logic [7:0]                    toggle_thr_q;
  logic [mcss_pkg::MS16_W-1:0]   reboot_ms_q;

  logic [mcss_pkg::RUN_S_W-1:0]  run_s_wr;
  logic [mcss_pkg::RUN_MS_W-1:0] run_ms_wr;
  logic                          run_wr_chg;

  // clamp to the legal run window
  always_comb begin
    run_s_wr = cfg_data_i[mcss_pkg::RUN_S_W-1:0];
    if (run_s_wr < mcss_pkg::RUN_S_MIN) begin
      run_s_wr = mcss_pkg::RUN_S_MIN;
    end else if (run_s_wr > mcss_pkg::RUN_S_MAX) begin
      run_s_wr = mcss_pkg::RUN_S_MAX;
    end
  end

  assign run_ms_wr  = mcss_pkg::RUN_MS_W'(run_s_wr) * mcss_pkg::MS_PER_S;
  assign run_wr_chg = cfg_we_i && (cfg_idx_i == mcss_pkg::REG_MAX_RUN_S)
                      && (run_s_wr != max_run_s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_s_q   <= mcss_pkg::RUN_S_RST;
      max_run_ms_q  <= mcss_pkg::RUN_MS_RST;
      no_pulse_ms_q <= mcss_pkg::NO_PULSE_MS_RST;
      toggle_thr_q  <= mcss_pkg::TOGGLE_THR_RST;
      reboot_ms_q   <= mcss_pkg::REBOOT_MS_RST;
    end else if (cfg_we_i) begin
      if (run_wr_chg) begin
        max_run_s_q  <= run_s_wr;
        max_run_ms_q <= run_ms_wr;
      end
      if (cfg_idx_i == mcss_pkg::REG_NO_PULSE_MS) begin
        no_pulse_ms_q <= cfg_data_i;
      end
      if (cfg_idx_i == mcss_pkg::REG_TOGGLE_THR) begin
        toggle_thr_q <= cfg_data_i[7:0];
      end
      if (cfg_idx_i == mcss_pkg::REG_REBOOT_MS) begin
        reboot_ms_q <= cfg_data_i;
      end
    end
  end

  assign cfg_o.max_run_ms  = max_run_ms_q;
  assign cfg_o.no_pulse_ms = no_pulse_ms_q;
  assign cfg_o.toggle_thr  = toggle_thr_q;
  assign cfg_o.reboot_ms   = reboot_ms_q;
  assign cfg_o.run_restart = run_wr_chg;

endmodule

>>> sv/mcss_core.sv
module mcss_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_en_i,
  input  mcss_pkg::in_word_t    word_i,
  input  mcss_pkg::cfg_t        cfg_i,
  output mcss_pkg::out_word_t   res_o
);

  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_SWITCH = 2'd1;
  localparam logic [1:0] SRC_REMOTE = 2'd2;

  // supervisor state
  logic [1:0]  sw_prev_q, sw_prev_d;
  logic [1:0]  sw_eff_q, sw_eff_d;
  logic        armed_q, armed_d;
  logic [1:0]  sw_lat_q, sw_lat_d;
  logic [1:0]  rem_lat_q, rem_lat_d;
  logic [1:0]  rem_prev_q, rem_prev_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] sw_seq_q, sw_seq_d;
  logic [31:0] rem_seq_q, rem_seq_d;
  logic        rclr_q, rclr_d;
  logic [1:0]  motion_q, motion_d;
  logic        set_q, set_d;
  logic        panic_q, panic_d;
  logic [7:0]  streak_q, streak_d;
  logic        sim_q, sim_d;
  logic        manual_q, manual_d;
  logic [1:0]  relay_prev_q, relay_prev_d;
  logic        run_q, run_d;
  logic [20:0] run_ms_q, run_ms_d;
  logic        watch_q, watch_d;
  logic [15:0] watch_ms_q, watch_ms_d;
  logic [31:0] wpos_q, wpos_d;
  logic        reb_q, reb_d;
  logic [15:0] reb_ms_q, reb_ms_d;

  // per-word scratch
  logic [1:0]  sw, rd, relay, neff, target, src, mode;
  logic [31:0] sel_seq, pos;
  logic        pclr, mark_o, mark_c, reboot_req;
  logic        trig_rt, trig_wd, trig_ft;
  logic [21:0] run_sum;
  logic [16:0] watch_sum, reb_sum;
  logic [42:0] sec_prod;
  logic [11:0] sec_quo;
  logic [10:0] secs;

  always_comb begin
    sw_prev_d    = sw_prev_q;
    sw_eff_d     = sw_eff_q;
    armed_d      = armed_q;
    sw_lat_d     = sw_lat_q;
    rem_lat_d    = rem_lat_q;
    rem_prev_d   = rem_prev_q;
    seq_d        = seq_q;
    sw_seq_d     = sw_seq_q;
    rem_seq_d    = rem_seq_q;
    rclr_d       = rclr_q;
    motion_d     = motion_q;
    set_d        = set_q;
    panic_d      = panic_q;
    streak_d     = streak_q;
    sim_d        = sim_q;
    manual_d     = manual_q;
    run_d        = run_q;
    run_ms_d     = run_ms_q;
    watch_d      = watch_q;
    watch_ms_d   = watch_ms_q;
    wpos_d       = wpos_q;
    reb_d        = reb_q;
    reb_ms_d     = reb_ms_q;
    pclr         = 1'b0;
    mark_o       = 1'b0;
    mark_c       = 1'b0;
    reboot_req   = 1'b0;
    neff         = mcss_pkg::MOT_IDLE;
    src          = SRC_NONE;
    sel_seq      = '0;
    trig_rt      = 1'b0;
    trig_wd      = 1'b0;
    trig_ft      = 1'b0;

    sw    = mcss_pkg::motion_of(word_i.switch_raw);
    rd    = mcss_pkg::motion_of(word_i.remote_desired);
    relay = mcss_pkg::motion_of(word_i.relay_state);
    pos   = word_i.pulse_position;

    // saturating timers
    run_sum   = {1'b0, run_ms_q} + 22'(word_i.delta_ms);
    watch_sum = {1'b0, watch_ms_q} + 17'(word_i.delta_ms);
    reb_sum   = {1'b0, reb_ms_q} + 17'(word_i.delta_ms);
    if (run_q) run_ms_d = run_sum[21] ? '1 : run_sum[20:0];
    if (watch_q) watch_ms_d = watch_sum[16] ? '1 : watch_sum[15:0];
    if (reb_q) reb_ms_d = reb_sum[16] ? '1 : reb_sum[15:0];

    // wall switch, armed by a return to neutral
    if (set_q) armed_d = 1'b0;
    if (sw != sw_prev_q) begin
      sw_prev_d = sw;
      if (sw == mcss_pkg::MOT_IDLE) begin
        armed_d = 1'b1;
        neff    = mcss_pkg::MOT_IDLE;
      end else if (armed_d) begin
        armed_d = 1'b0;
        neff    = sw;
      end else begin
        neff = mcss_pkg::MOT_IDLE;
      end
      if (neff != sw_eff_q) begin
        if (neff != mcss_pkg::MOT_IDLE) begin
          rclr_d = 1'b1;
          pclr   = 1'b1;
        end
        streak_d = '0;
        sw_eff_d = neff;
        sw_lat_d = neff;
        seq_d    = seq_d + 32'd1;
        sw_seq_d = seq_d;
      end
    end

    // remote command
    unique case (word_i.func)
      mcss_pkg::FUNC_NONE: begin
      end
      mcss_pkg::FUNC_MARK_OPEN: begin
        streak_d = '0;
        mark_o   = 1'b1;
      end
      mcss_pkg::FUNC_MARK_CLOSED: begin
        streak_d = '0;
        mark_c   = 1'b1;
      end
      mcss_pkg::FUNC_ENTER_SET: begin
        if (streak_d != 8'hFF) begin
          streak_d = streak_d + 8'd1;
          if (streak_d >= cfg_i.toggle_thr) begin
            sim_d    = !sim_d;
            streak_d = '0;
          end
        end
        if (!set_d) begin
          set_d     = 1'b1;
          rclr_d    = 1'b1;
          pclr      = 1'b1;
          panic_d   = 1'b0;
          armed_d   = 1'b0;
          sw_eff_d  = mcss_pkg::MOT_IDLE;
          sw_prev_d = sw;
          sw_lat_d  = mcss_pkg::MOT_IDLE;
          seq_d     = seq_d + 32'd1;
          sw_seq_d  = seq_d;
        end
      end
      mcss_pkg::FUNC_EXIT_SET: begin
        streak_d = '0;
        if (set_d) begin
          set_d     = 1'b0;
          rclr_d    = 1'b1;
          pclr      = 1'b1;
          sw_prev_d = sw;
          armed_d   = (sw == mcss_pkg::MOT_IDLE);
          sw_lat_d  = mcss_pkg::MOT_IDLE;
          seq_d     = seq_d + 32'd1;
          sw_seq_d  = seq_d;
        end
      end
      default: begin
        streak_d = '0;
      end
    endcase

    // remote desired motion
    if (pclr) rd = mcss_pkg::MOT_IDLE;
    if (rd != rem_prev_d) begin
      rem_prev_d = rd;
      rem_lat_d  = rd;
      if (rclr_d && (rd == mcss_pkg::MOT_IDLE)) begin
        rclr_d = 1'b0;
      end else begin
        rclr_d    = 1'b0;
        seq_d     = seq_d + 32'd1;
        rem_seq_d = seq_d;
      end
    end

    // newest source wins
    target = panic_d ? mcss_pkg::MOT_IDLE : motion_q;
    if (!panic_d) begin
      if (sw_seq_d > sel_seq) begin
        sel_seq = sw_seq_d;
        target  = sw_lat_d;
        src     = SRC_SWITCH;
      end
      if (rem_seq_d > sel_seq) begin
        target = rem_lat_d;
        src    = SRC_REMOTE;
      end
    end

    if (src == SRC_SWITCH) begin
      if (!manual_q && run_q) run_ms_d = '0;
      manual_d = 1'b1;
    end else begin
      manual_d = 1'b0;
    end

    // limits, bypassed in set mode
    if (!set_d) begin
      if ((target == mcss_pkg::MOT_OPEN) && !word_i.can_open) begin
        run_ms_d = '0;
        target   = mcss_pkg::MOT_IDLE;
        if (src == SRC_REMOTE) begin
          rclr_d = 1'b1;
          pclr   = 1'b1;
        end
      end
      if ((target == mcss_pkg::MOT_CLOSE) && !word_i.can_close) begin
        run_ms_d = '0;
        target   = mcss_pkg::MOT_IDLE;
        if (src == SRC_REMOTE) begin
          rclr_d = 1'b1;
          pclr   = 1'b1;
        end
      end
    end

    // a switch command is used once
    if (src == SRC_SWITCH) begin
      if (sw_eff_d != mcss_pkg::MOT_IDLE) armed_d = 1'b0;
      sw_lat_d   = mcss_pkg::MOT_IDLE;
      sw_seq_d   = '0;
      rem_lat_d  = mcss_pkg::MOT_IDLE;
      rem_seq_d  = '0;
      rem_prev_d = mcss_pkg::MOT_IDLE;
    end

    mode = set_d ? mcss_pkg::MODE_SET :
           ((src == SRC_REMOTE) ? mcss_pkg::MODE_AUTO : mcss_pkg::MODE_LOCAL);
    motion_d = target;

    // drive timing
    if (relay != mcss_pkg::MOT_IDLE) begin
      if (!run_q || (relay_prev_q == mcss_pkg::MOT_IDLE)) begin
        run_d      = 1'b1;
        run_ms_d   = '0;
        watch_d    = 1'b1;
        watch_ms_d = '0;
        wpos_d     = pos;
      end
    end else begin
      run_d    = 1'b0;
      run_ms_d = '0;
      watch_d  = 1'b0;
    end
    relay_prev_d = relay;

    // guards; at most one panic trigger per word
    trig_rt = run_d && (run_ms_d >= cfg_i.max_run_ms) && !panic_d;
    if (watch_d && !trig_rt) begin
      if (pos != wpos_d) begin
        watch_d = 1'b0;
      end else if (watch_ms_d >= cfg_i.no_pulse_ms) begin
        trig_wd = !panic_d;
        watch_d = 1'b0;
      end
    end
    trig_ft = !trig_rt && !trig_wd && !set_d && word_i.position_fault && !panic_d;

    if (trig_rt || trig_wd || trig_ft) begin
      panic_d  = 1'b1;
      motion_d = mcss_pkg::MOT_IDLE;
      rclr_d   = 1'b1;
      pclr     = 1'b1;
      streak_d = '0;
      sw_lat_d = mcss_pkg::MOT_IDLE;
      seq_d    = seq_d + 32'd1;
      sw_seq_d = seq_d;
      run_d    = 1'b0;
      run_ms_d = '0;
      watch_d  = 1'b0;
      if (trig_rt || trig_wd) begin
        reb_d    = 1'b1;
        reb_ms_d = '0;
      end
    end

    if (reb_d && (reb_ms_d >= cfg_i.reboot_ms)) begin
      reb_d      = 1'b0;
      reboot_req = 1'b1;
    end

    // whole seconds by reciprocal multiply
    sec_prod = 43'(run_ms_d) * 43'(mcss_pkg::SEC_RECIP);
    sec_quo  = sec_prod[42:mcss_pkg::SEC_SHIFT];
    if (!run_d) begin
      secs = '0;
    end else if (sec_quo > 12'(mcss_pkg::RUN_S_MAX)) begin
      secs = mcss_pkg::RUN_S_MAX;
    end else begin
      secs = sec_quo[10:0];
    end
  end

  assign res_o.commanded_motion = motion_d;
  assign res_o.mode             = mode;
  assign res_o.panic            = panic_d;
  assign res_o.reboot_request   = reboot_req;
  assign res_o.drive_active     = run_d;
  assign res_o.runtime_seconds  = secs;
  assign res_o.clear_remote     = pclr;
  assign res_o.simulation_on    = sim_d;
  assign res_o.mark_open        = mark_o;
  assign res_o.mark_closed      = mark_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_prev_q    <= mcss_pkg::MOT_IDLE;
      sw_eff_q     <= mcss_pkg::MOT_IDLE;
      armed_q      <= 1'b1;
      sw_lat_q     <= mcss_pkg::MOT_IDLE;
      rem_lat_q    <= mcss_pkg::MOT_IDLE;
      rem_prev_q   <= mcss_pkg::MOT_IDLE;
      seq_q        <= '0;
      sw_seq_q     <= '0;
      rem_seq_q    <= '0;
      rclr_q       <= 1'b0;
      motion_q     <= mcss_pkg::MOT_IDLE;
      set_q        <= 1'b0;
      panic_q      <= 1'b0;
      streak_q     <= '0;
      sim_q        <= 1'b0;
      manual_q     <= 1'b0;
      relay_prev_q <= mcss_pkg::MOT_IDLE;
      run_q        <= 1'b0;
      run_ms_q     <= '0;
      watch_q      <= 1'b0;
      watch_ms_q   <= '0;
      wpos_q       <= '0;
      reb_q        <= 1'b0;
      reb_ms_q     <= '0;
    end else begin
      if (step_en_i) begin
        sw_prev_q    <= sw_prev_d;
        sw_eff_q     <= sw_eff_d;
        armed_q      <= armed_d;
        sw_lat_q     <= sw_lat_d;
        rem_lat_q    <= rem_lat_d;
        rem_prev_q   <= rem_prev_d;
        seq_q        <= seq_d;
        sw_seq_q     <= sw_seq_d;
        rem_seq_q    <= rem_seq_d;
        rclr_q       <= rclr_d;
        motion_q     <= motion_d;
        set_q        <= set_d;
        panic_q      <= panic_d;
        streak_q     <= streak_d;
        sim_q        <= sim_d;
        manual_q     <= manual_d;
        relay_prev_q <= relay_prev_d;
        run_q        <= run_d;
        run_ms_q     <= run_ms_d;
        watch_q      <= watch_d;
        watch_ms_q   <= watch_ms_d;
        wpos_q       <= wpos_d;
        reb_q        <= reb_d;
        reb_ms_q     <= reb_ms_d;
      end
      // a new run limit restarts the run timer
      if (cfg_i.run_restart) begin
        run_ms_q <= '0;
      end
    end
  end

endmodule

>>> tb/motor_command_safety_supervisor_top_test.sv
`timescale 1ns / 1ps

module motor_command_safety_supervisor_top_test;
  import mcss_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int STALL_LIMIT = 4000;   // cycles with no word moving on either side
  localparam int GAP_PCT = 62;         // idle / stall odds, single side
  localparam int BOTH_PCT = 22;        // idle / stall odds, both sides at once
  localparam int PHASE_TICKS = 250;
  localparam int DRAIN_CYCLES = 10;    // two-stage pipe, plenty of slack

  // encodings the package leaves unnamed
  localparam logic [1:0] MOT_CODE3 = 2'd3;      // reads as idle
  localparam logic [2:0] FUNC_OTHER = 3'd5;     // unknown command
  localparam logic [2:0] FUNC_TOP = 3'd7;       // unknown command, all bits set
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;  // no register there

  // who won arbitration this tick
  localparam int unsigned SRC_NONE = 0;
  localparam int unsigned SRC_SWITCH = 1;
  localparam int unsigned SRC_REMOTE = 2;

  localparam logic [31:0] RUN_MS_SAT = 32'h001F_FFFF;
  localparam logic [31:0] MS16_SAT = 32'h0000_FFFF;

  typedef enum {IDLE_OFF, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mcss_stream_if #(.word_t(in_word_t)) tick_if ();
  mcss_stream_if #(.word_t(out_word_t)) result_if ();

  motor_command_safety_supervisor_top i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (tick_if),
    .out_o     (result_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  wire tick_fire = tick_if.valid & tick_if.ready;
  wire result_fire = result_if.valid & result_if.ready;

  always #(CLK_PERIOD / 2) clk = ~clk;

  in_word_t pending_ticks[$];        // words waiting for the driver
  out_word_t expected_results[$];    // predicted result words, oldest first
  idle_mode_e idle_mode = IDLE_OFF;
  int n_errors = 0;
  int idle_cycles = 0;

  // ---------------------------------------------------------------------
  // Supervisor predictor: private copy of the block state and registers.
  // ---------------------------------------------------------------------
  logic [1:0]  sw_prev, sw_eff, sw_latch, rem_latch, rem_prev, motion_q, relay_prev_q;
  logic        edge_armed_q, rem_cleared, set_mode_q, panic_q, sim_q, manual_armed_q;
  logic        run_q, watch_q, reboot_pend_q, clear_pulse;
  logic [7:0]  enter_streak_q;
  logic [31:0] seq_cnt, sw_seq, rem_seq, watch_pos;
  logic [20:0] run_ms_q;
  logic [15:0] watch_ms_q, reboot_ms_q;
  // register shadows
  logic [10:0] max_run_s;
  logic [15:0] no_pulse_ms, reboot_delay;
  logic [7:0]  toggle_thr;

  function automatic void model_reset();
    sw_prev = MOT_IDLE; sw_eff = MOT_IDLE; sw_latch = MOT_IDLE;
    rem_latch = MOT_IDLE; rem_prev = MOT_IDLE; motion_q = MOT_IDLE; relay_prev_q = MOT_IDLE;
    edge_armed_q = 1'b1; rem_cleared = 1'b0; set_mode_q = 1'b0; panic_q = 1'b0;
    sim_q = 1'b0; manual_armed_q = 1'b0;
    run_q = 1'b0; watch_q = 1'b0; reboot_pend_q = 1'b0; clear_pulse = 1'b0;
    enter_streak_q = '0;
    seq_cnt = '0; sw_seq = '0; rem_seq = '0; watch_pos = '0;
    run_ms_q = '0; watch_ms_q = '0; reboot_ms_q = '0;
    max_run_s = RUN_S_RST;
    no_pulse_ms = NO_PULSE_MS_RST;
    toggle_thr = TOGGLE_THR_RST;
    reboot_delay = REBOOT_MS_RST;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    logic [10:0] secs;
    secs = data[10:0];
    case (idx)
      REG_MAX_RUN_S: begin
        if (secs < RUN_S_MIN) secs = RUN_S_MIN;
        else if (secs > RUN_S_MAX) secs = RUN_S_MAX;
        // only a real change restarts the run timer
        if (secs != max_run_s) begin
          max_run_s = secs;
          run_ms_q = '0;
        end
      end
      REG_NO_PULSE_MS: no_pulse_ms = data;
      REG_TOGGLE_THR:  toggle_thr = data[7:0];
      REG_REBOOT_MS:   reboot_delay = data;
      default: ;
    endcase
  endfunction

  // code three on a motion field reads as idle
  function automatic logic [1:0] as_motion(logic [1:0] v);
    return (&v) ? MOT_IDLE : v;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b, logic [31:0] top);
    logic [31:0] s;
    s = a + b;
    return (s > top) ? top : s;
  endfunction

  function automatic logic [31:0] next_seq();
    seq_cnt = seq_cnt + 32'd1;
    return seq_cnt;
  endfunction

  function automatic void ask_clear();
    rem_cleared = 1'b1;
    clear_pulse = 1'b1;
  endfunction

  // first fault wins; later ones are ignored until set mode clears panic
  function automatic void trigger_panic(bit with_reboot);
    if (!panic_q) begin
      panic_q = 1'b1;
      motion_q = MOT_IDLE;
      ask_clear();
      enter_streak_q = '0;
      sw_latch = MOT_IDLE;
      sw_seq = next_seq();
      run_q = 1'b0;
      run_ms_q = '0;
      watch_q = 1'b0;
      if (with_reboot) begin
        reboot_pend_q = 1'b1;
        reboot_ms_q = '0;
      end
    end
  endfunction

  // One tick through the supervisor; returns the result word it produces.
  function automatic out_word_t supervise_tick(in_word_t w);
    logic [1:0] sw, rd, relay, target, neff;
    logic [31:0] pos, sel_seq, secs, run_limit;
    int unsigned src;
    logic mark_o, mark_c, reboot_req;
    out_word_t r;
    sw = as_motion(w.switch_raw);
    rd = as_motion(w.remote_desired);
    relay = as_motion(w.relay_state);
    pos = w.pulse_position;
    mark_o = 1'b0;
    mark_c = 1'b0;
    reboot_req = 1'b0;
    src = SRC_NONE;
    sel_seq = '0;
    clear_pulse = 1'b0;

    // timers advance first, saturating
    if (run_q) run_ms_q = 21'(sat_add(32'(run_ms_q), 32'(w.delta_ms), RUN_MS_SAT));
    if (watch_q) watch_ms_q = 16'(sat_add(32'(watch_ms_q), 32'(w.delta_ms), MS16_SAT));
    if (reboot_pend_q) reboot_ms_q = 16'(sat_add(32'(reboot_ms_q), 32'(w.delta_ms), MS16_SAT));

    // wall switch: a move counts only when armed; neutral re-arms
    if (set_mode_q) edge_armed_q = 1'b0;
    if (sw != sw_prev) begin
      sw_prev = sw;
      if (sw == MOT_IDLE) begin
        edge_armed_q = 1'b1;
        neff = MOT_IDLE;
      end else if (edge_armed_q) begin
        edge_armed_q = 1'b0;
        neff = sw;
      end else begin
        neff = MOT_IDLE;
      end
      if (neff != sw_eff) begin
        if (neff != MOT_IDLE) ask_clear();
        enter_streak_q = '0;
        sw_eff = neff;
        sw_latch = neff;
        sw_seq = next_seq();
      end
    end

    // remote command
    case (w.func)
      FUNC_NONE: ;
      FUNC_MARK_OPEN: begin
        enter_streak_q = '0;
        mark_o = 1'b1;
      end
      FUNC_MARK_CLOSED: begin
        enter_streak_q = '0;
        mark_c = 1'b1;
      end
      FUNC_ENTER_SET: begin
        if (enter_streak_q < 8'd255) begin
          enter_streak_q = enter_streak_q + 8'd1;
          if (enter_streak_q >= toggle_thr) begin
            sim_q = !sim_q;
            enter_streak_q = '0;
          end
        end
        if (!set_mode_q) begin
          set_mode_q = 1'b1;
          ask_clear();
          panic_q = 1'b0;
          edge_armed_q = 1'b0;
          sw_eff = MOT_IDLE;
          sw_prev = sw;
          sw_latch = MOT_IDLE;
          sw_seq = next_seq();
        end
      end
      FUNC_EXIT_SET: begin
        enter_streak_q = '0;
        if (set_mode_q) begin
          set_mode_q = 1'b0;
          ask_clear();
          sw_prev = sw;
          edge_armed_q = (sw == MOT_IDLE);
          sw_latch = MOT_IDLE;
          sw_seq = next_seq();
        end
      end
      default: enter_streak_q = '0;
    endcase

    // remote desired motion; a clear raised earlier this tick masks it
    if (clear_pulse) rd = MOT_IDLE;
    if (rd != rem_prev) begin
      rem_prev = rd;
      rem_latch = rd;
      if (rem_cleared && rd == MOT_IDLE) begin
        rem_cleared = 1'b0;
      end else begin
        rem_cleared = 1'b0;
        rem_seq = next_seq();
      end
    end

    // newest source wins
    target = panic_q ? MOT_IDLE : motion_q;
    if (!panic_q) begin
      if (sw_seq > sel_seq) begin
        sel_seq = sw_seq;
        target = sw_latch;
        src = SRC_SWITCH;
      end
      if (rem_seq > sel_seq) begin
        sel_seq = rem_seq;
        target = rem_latch;
        src = SRC_REMOTE;
      end
    end

    if (src == SRC_SWITCH) begin
      if (!manual_armed_q && run_q) run_ms_q = '0;
      manual_armed_q = 1'b1;
    end else begin
      manual_armed_q = 1'b0;
    end

    // limits, outside set mode only
    if (!set_mode_q) begin
      if (target == MOT_OPEN && !w.can_open) begin
        run_ms_q = '0;
        target = MOT_IDLE;
        if (src == SRC_REMOTE) ask_clear();
      end
      if (target == MOT_CLOSE && !w.can_close) begin
        run_ms_q = '0;
        target = MOT_IDLE;
        if (src == SRC_REMOTE) ask_clear();
      end
    end

    // a switch command is used once, and drops the remote latch with it
    if (src == SRC_SWITCH) begin
      if (sw_eff != MOT_IDLE) edge_armed_q = 1'b0;
      sw_latch = MOT_IDLE;
      sw_seq = '0;
      rem_latch = MOT_IDLE;
      rem_seq = '0;
      rem_prev = MOT_IDLE;
    end

    r.mode = set_mode_q ? MODE_SET : ((src == SRC_REMOTE) ? MODE_AUTO : MODE_LOCAL);
    motion_q = target;

    // drive timing follows the relay
    if (relay != MOT_IDLE) begin
      if (!run_q || relay_prev_q == MOT_IDLE) begin
        run_q = 1'b1;
        run_ms_q = '0;
        watch_q = 1'b1;
        watch_ms_q = '0;
        watch_pos = pos;
      end
    end else begin
      run_q = 1'b0;
      run_ms_q = '0;
      watch_q = 1'b0;
    end
    relay_prev_q = relay;

    run_limit = 32'(max_run_s) * 32'(MS_PER_S);
    if (run_q && max_run_s != '0 && 32'(run_ms_q) >= run_limit) trigger_panic(1'b1);

    if (watch_q) begin
      if (pos != watch_pos) begin
        watch_q = 1'b0;
      end else if (watch_ms_q >= no_pulse_ms) begin
        trigger_panic(1'b1);
        watch_q = 1'b0;
      end
    end

    // position fault panics without a reboot
    if (!set_mode_q && w.position_fault && !panic_q) trigger_panic(1'b0);

    if (reboot_pend_q && reboot_ms_q >= reboot_delay) begin
      reboot_pend_q = 1'b0;
      reboot_req = 1'b1;
    end

    secs = run_q ? 32'(run_ms_q) / 32'(MS_PER_S) : 32'd0;
    if (secs > 32'(RUN_S_MAX)) secs = 32'(RUN_S_MAX);

    r.commanded_motion = motion_q;
    r.panic = panic_q;
    r.reboot_request = reboot_req;
    r.drive_active = run_q;
    r.runtime_seconds = secs[10:0];
    r.clear_remote = clear_pulse;
    r.simulation_on = sim_q;
    r.mark_open = mark_o;
    r.mark_closed = mark_c;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic bit chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic void push_tick(logic [2:0] func, logic [1:0] sw, logic [1:0] rd,
                                    logic co, logic cc, logic [1:0] relay,
                                    logic [31:0] pos, logic fault, logic [15:0] delta);
    in_word_t w;
    w.func = func;
    w.switch_raw = sw;
    w.remote_desired = rd;
    w.can_open = co;
    w.can_close = cc;
    w.relay_state = relay;
    w.pulse_position = pos;
    w.position_fault = fault;
    w.delta_ms = delta;
    pending_ticks.push_back(w);
  endfunction

  // elapsed time mix: mostly short ticks, some long, a few extremes
  function automatic logic [15:0] rand_delta();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return chance(50) ? 16'hFFFF : 16'h0000;
    if (pick < 4) return 16'($urandom_range(100));
    if (pick < 8) return 16'($urandom_range(5000));
    return 16'($urandom_range(65535));
  endfunction

  // slowly drifting plant: switch, remote, relay and position persist
  logic [1:0]  gen_switch = MOT_IDLE, gen_remote = MOT_IDLE, gen_relay = MOT_IDLE;
  logic [31:0] gen_pos = '0;
  logic        gen_co = 1'b1, gen_cc = 1'b1;

  function automatic void wander();
    if (chance(20)) gen_switch = 2'($urandom_range(3));
    if (chance(15)) gen_remote = 2'($urandom_range(3));
    if (chance(12)) gen_relay = 2'($urandom_range(3));
    if (chance(40)) begin
      if (chance(20)) gen_pos = $urandom;
      else gen_pos = gen_pos + 32'($urandom_range(8)) - 32'd4;
    end
    gen_co = chance(85);
    gen_cc = chance(85);
  endfunction

  function automatic void push_scene(logic [2:0] func);
    push_tick(func, gen_switch, gen_remote, gen_co, gen_cc, gen_relay, gen_pos,
              chance(3), rand_delta());
  endfunction

  function automatic void random_ticks(int unsigned n);
    int unsigned made;
    made = 0;
    while (made < n) begin
      if (chance(2)) begin
        // long stuck run: panics, then keeps timing until the seconds saturate
        gen_relay = MOT_OPEN;
        for (int i = 0; i < 36; i++)
          push_tick(FUNC_NONE, gen_switch, gen_remote, 1'b1, 1'b1, gen_relay, gen_pos,
                    1'b0, 16'hFFFF);
        made += 36;
      end else if (chance(4)) begin
        // set-mode session: enter, jog around, mark an end, leave
        push_scene(FUNC_ENTER_SET);
        repeat (2) begin
          wander();
          push_scene(FUNC_NONE);
        end
        push_scene(chance(50) ? FUNC_MARK_OPEN : FUNC_MARK_CLOSED);
        push_scene(FUNC_EXIT_SET);
        made += 5;
      end else begin
        wander();
        push_scene(chance(55) ? FUNC_NONE : 3'($urandom_range(7)));
        made++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Config port; callers guarantee nothing is in flight
  // ---------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    apply_cfg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] run_s, input logic [15:0] window,
                           input logic [15:0] thr, input logic [15:0] delay);
    write_reg(REG_MAX_RUN_S, run_s);
    write_reg(REG_NO_PULSE_MS, window);
    write_reg(REG_TOGGLE_THR, thr);
    write_reg(REG_REBOOT_MS, delay);
  endtask

  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || tick_if.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued tick words, predicts each one as it is taken
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      tick_if.valid <= 1'b0;
    end else begin
      if (tick_fire) expected_results.push_back(supervise_tick(tick_if.data));
      // a word on the bus stays put until it is taken
      if (!tick_if.valid || tick_if.ready) begin
        if (pending_ticks.size() != 0 &&
            !((idle_mode == IDLE_SENDER && chance(GAP_PCT)) ||
              (idle_mode == IDLE_BOTH && chance(BOTH_PCT)))) begin
          tick_if.valid <= 1'b1;
          tick_if.data <= pending_ticks.pop_front();
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= !((idle_mode == IDLE_RECEIVER && chance(GAP_PCT)) ||
                           (idle_mode == IDLE_BOTH && chance(BOTH_PCT)));
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every result word against the oldest prediction
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && result_fire) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word %p", $time, result_if.data);
        n_errors++;
      end else begin
        out_word_t want;
        want = expected_results.pop_front();
        check_field("commanded_motion", want.commanded_motion, result_if.data.commanded_motion);
        check_field("mode", want.mode, result_if.data.mode);
        check_field("panic", want.panic, result_if.data.panic);
        check_field("reboot_request", want.reboot_request, result_if.data.reboot_request);
        check_field("drive_active", want.drive_active, result_if.data.drive_active);
        check_field("runtime_seconds", want.runtime_seconds, result_if.data.runtime_seconds);
        check_field("clear_remote", want.clear_remote, result_if.data.clear_remote);
        check_field("simulation_on", want.simulation_on, result_if.data.simulation_on);
        check_field("mark_open", want.mark_open, result_if.data.mark_open);
        check_field("mark_closed", want.mark_closed, result_if.data.mark_closed);
      end
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk) begin
    if (tick_fire || result_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("motor_command_safety_supervisor_top_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    tick_if.valid = 1'b0;
    tick_if.data = '0;
    result_if.ready = 1'b0;
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, registers at reset values (300 s, 5000 ms, 3, 500 ms).
    // all-zero word
    push_tick(FUNC_NONE, MOT_IDLE, MOT_IDLE, 1'b0, 1'b0, MOT_IDLE, 32'h0, 1'b0, 16'd0);
    // switch to open while armed, then held with the relay running
    push_tick(FUNC_NONE, MOT_OPEN, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'h1234, 1'b0, 16'd10);
    push_tick(FUNC_NONE, MOT_OPEN, MOT_IDLE, 1'b1, 1'b1, MOT_OPEN, 32'h1234, 1'b0, 16'd20);
    // back to neutral re-arms; position moved so the no-pulse watch stops
    push_tick(FUNC_NONE, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_OPEN, 32'h1235, 1'b0, 16'd20);
    // close blocked by the limit
    push_tick(FUNC_NONE, MOT_CLOSE, MOT_IDLE, 1'b1, 1'b0, MOT_IDLE, 32'h1235, 1'b0, 16'd20);
    // code three on switch and relay reads as neutral / idle
    push_tick(FUNC_NONE, MOT_CODE3, MOT_IDLE, 1'b1, 1'b1, MOT_CODE3, 32'h1235, 1'b0, 16'd20);
    // remote open, remote close against the limit (clears remote), remote code three
    push_tick(FUNC_NONE, MOT_IDLE, MOT_OPEN, 1'b1, 1'b1, MOT_IDLE, 32'h1235, 1'b0, 16'd20);
    push_tick(FUNC_NONE, MOT_IDLE, MOT_CLOSE, 1'b1, 1'b0, MOT_IDLE, 32'h1235, 1'b0, 16'd20);
    push_tick(FUNC_NONE, MOT_IDLE, MOT_CODE3, 1'b1, 1'b1, MOT_IDLE, 32'h1235, 1'b0, 16'd20);
    // mark pulses and unknown commands
    push_tick(FUNC_MARK_OPEN, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'h0, 1'b0, 16'd1);
    push_tick(FUNC_MARK_CLOSED, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'h0, 1'b0, 16'd1);
    push_tick(FUNC_OTHER, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'h0, 1'b0, 16'd1);
    push_tick(FUNC_TOP, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'h0, 1'b0, 16'd1);
    // three enters: first masks the remote within the tick, third toggles simulation
    push_tick(FUNC_ENTER_SET, MOT_IDLE, MOT_OPEN, 1'b1, 1'b1, MOT_IDLE, 32'h0, 1'b0, 16'd1);
    push_tick(FUNC_ENTER_SET, MOT_IDLE, MOT_OPEN, 1'b1, 1'b1, MOT_IDLE, 32'h0, 1'b0, 16'd1);
    push_tick(FUNC_ENTER_SET, MOT_IDLE, MOT_OPEN, 1'b1, 1'b1, MOT_IDLE, 32'h0, 1'b0, 16'd1);
    // leave set mode with the switch held: stays disarmed
    push_tick(FUNC_EXIT_SET, MOT_OPEN, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'h0, 1'b0, 16'd1);
    // drive at max position, no pulses: panic with reboot, then the reboot pulse
    push_tick(FUNC_NONE, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_CLOSE, 32'h7FFF_FFFF, 1'b0, 16'd0);
    push_tick(FUNC_NONE, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_CLOSE, 32'h7FFF_FFFF, 1'b0,
              16'hFFFF);
    push_tick(FUNC_NONE, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_CLOSE, 32'h7FFF_FFFF, 1'b0,
              16'hFFFF);
    // set mode clears panic; a fault inside set mode is ignored
    push_tick(FUNC_ENTER_SET, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'h8000_0000, 1'b1,
              16'd100);
    push_tick(FUNC_EXIT_SET, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'h8000_0000, 1'b0,
              16'd100);
    // fault outside set mode: panic without reboot
    push_tick(FUNC_NONE, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'hFFFF_FFFF, 1'b1, 16'd100);
    push_tick(FUNC_ENTER_SET, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'h0, 1'b0, 16'd100);
    push_tick(FUNC_EXIT_SET, MOT_IDLE, MOT_IDLE, 1'b1, 1'b1, MOT_IDLE, 32'h0, 1'b0, 16'd100);
    wait_drained();

    // Random phases, each with its own register set and idling pattern.
    // shortest run (0 clamps up to 30 s), tightest window, threshold 1, no delay
    configure(16'd0, 16'd100, 16'd1, 16'd0);
    idle_mode = IDLE_OFF;
    random_ticks(PHASE_TICKS);
    wait_drained();

    // longest run, threshold and delay, long window; 2047 clamps down to 1800 s
    configure(16'd2047, 16'd60000, 16'd255, 16'd65535);
    idle_mode = IDLE_SENDER;
    random_ticks(PHASE_TICKS);
    wait_drained();

    // threshold zero toggles on every enter; spare index must be ignored
    configure(16'd30, 16'd2000, 16'd0, 16'd1000);
    write_reg(REG_SPARE, 16'hFFFF);
    idle_mode = IDLE_RECEIVER;
    random_ticks(PHASE_TICKS);
    wait_drained();

    // 12 clamps to 30 s, unchanged, so a running timer keeps counting
    configure(16'd12, 16'd800, 16'd2, 16'd200);
    idle_mode = IDLE_BOTH;
    random_ticks(PHASE_TICKS);
    wait_drained();

    idle_mode = IDLE_OFF;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("motor_command_safety_supervisor_top_test: PASS");
    end else begin
      $display("motor_command_safety_supervisor_top_test: FAIL");
    end
    $finish;
  end

endmodule

>>> motor_command_safety_supervisor_top.f
sv/mcss_pkg.sv
sv/mcss_stream_if.sv
sv/mcss_cfg.sv
sv/mcss_core.sv
sv/motor_command_safety_supervisor_top.sv
tb/motor_command_safety_supervisor_top_test.sv
